// ----- rtl/epbf_pkg.sv -----
// Package for the endian packing byte FIFO: sizes, command and status codes,
// controller states and the control/status structs between controller and datapath.
// No dependencies.
package epbf_pkg;

    // Byte store depth; must be a power of two so that ring pointers wrap naturally.
    localparam int DEPTH   = 1024;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int CNT_W   = PTR_W + 1;
    localparam int OFF_W   = 10;
    localparam int WORD_W  = 64;
    localparam int FILL_W  = 11;
    localparam int SIZE_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int LANE_W  = 3;
    // Wide enough for fill + 8 and for offset + 8 without overflow
    localparam int CHK_W   = ((CNT_W > OFF_W) ? CNT_W : OFF_W) + 1;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_UNDERFLOW  = 2'd1,
        ST_OVERFLOW   = 2'd2,
        ST_PEEK_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_READ,
        S_DRAIN,
        S_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic accept;    // input transfer this cycle
        logic wr_byte;   // write one byte to the store
        logic rd_issue;  // issue one byte read address
        logic commit;    // update head/count for a write or read-pop
        logic load_out;  // load the output register
    } t_dp_ctl;

    // Datapath to controller
    typedef struct packed {
        t_cmd cmd_in;    // command of the offered input item
        logic err_in;    // offered item fails its range check
        logic last;      // current byte index is the last of the element
    } t_dp_stat;

    // Index of the last byte lane of an element of the given size code
    function automatic logic [LANE_W-1:0] f_last_lane(input logic [SIZE_W-1:0] size);
        logic [LANE_W:0] nbytes;
        begin
            nbytes = (LANE_W + 1)'(1) << size;
            return LANE_W'(nbytes - (LANE_W + 1)'(1));
        end
    endfunction

endpackage

// ----- rtl/epbf_if.sv -----
// Channel interfaces for the endian packing byte FIFO: command, response, configuration.
// Widths follow the item fields; no package dependency.
interface epbf_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [1:0]  size_code;
    logic [63:0] write_word;
    logic [9:0]  peek_offset;

    modport source (output valid, command, size_code, write_word, peek_offset,
                    input ready);
    modport sink   (input valid, command, size_code, write_word, peek_offset,
                    output ready);
endinterface

interface epbf_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] read_word;
    logic [10:0] fill_level;
    logic [1:0]  status;

    modport source (output valid, read_word, fill_level, status, input ready);
    modport sink   (input valid, read_word, fill_level, status, output ready);
endinterface

interface epbf_cfg_if;
    logic valid;
    logic ready;
    logic big_endian_order;

    modport source (output valid, big_endian_order, input ready);
    modport sink   (input valid, big_endian_order, output ready);
endinterface

// ----- rtl/epbf_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module epbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/epbf_ctrl.sv -----
// Controller state machine of the endian packing byte FIFO.
// Depends on epbf_pkg; drives the datapath through t_dp_ctl, watches t_dp_stat.
module epbf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  epbf_pkg::t_dp_stat i_stat,
    output epbf_pkg::t_dp_ctl  o_ctl,
    output logic              o_out_valid,
    input  logic              i_out_ready
);
    import epbf_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;

    assign w_out_free = !r_out_valid || i_out_ready;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.err_in || i_stat.cmd_in == CMD_CLEAR) begin
                        n_state = S_DONE;
                    end else if (i_stat.cmd_in == CMD_WRITE) begin
                        n_state = S_WRITE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_WRITE: begin
                if (i_stat.last) begin
                    n_state = S_DONE;
                end
            end
            S_READ: begin
                if (i_stat.last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = S_DONE;
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs; no command transfer is taken while reset is held
    always_comb begin
        o_in_ready     = 1'b0;
        o_ctl          = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready   = i_rst_n;
                o_ctl.accept = i_in_valid && i_rst_n;
            end
            S_WRITE: begin
                o_ctl.wr_byte = 1'b1;
                o_ctl.commit  = i_stat.last;
            end
            S_READ:  o_ctl.rd_issue = 1'b1;
            S_DRAIN: o_ctl.commit   = 1'b1;
            S_DONE:  o_ctl.load_out = w_out_free;
            default: o_in_ready     = 1'b0;
        endcase
    end

    // Output valid: set on load, cleared by a response transfer
    always_comb begin
        n_out_valid = r_out_valid && !i_out_ready;
        if (o_ctl.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load_out |-> (!r_out_valid || i_out_ready))
        else $error("output register loaded while holding an untaken result");
    a_valid_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("response raised outside the done state");
    a_no_mem_when_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (!o_ctl.wr_byte && !o_ctl.rd_issue && !o_ctl.commit))
        else $error("store access while taking new items");
`endif

endmodule

// ----- rtl/epbf_dp.sv -----
// Datapath of the endian packing byte FIFO: ring pointers, byte store, packing and
// unpacking of words, output register. Depends on epbf_pkg and epbf_ram.
module epbf_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  epbf_pkg::t_dp_ctl              i_ctl,
    output epbf_pkg::t_dp_stat             o_stat,
    input  epbf_pkg::t_cmd                 i_command,
    input  logic [epbf_pkg::SIZE_W-1:0]    i_size_code,
    input  logic [epbf_pkg::WORD_W-1:0]    i_write_word,
    input  logic [epbf_pkg::OFF_W-1:0]     i_peek_offset,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_big_endian_order,
    output logic [epbf_pkg::WORD_W-1:0]    o_read_word,
    output logic [epbf_pkg::FILL_W-1:0]    o_fill_level,
    output epbf_pkg::t_status              o_status
);
    import epbf_pkg::*;

    // Control state
    logic [PTR_W-1:0]  r_head;
    logic [CNT_W-1:0]  r_count;
    logic              r_big_endian;
    logic              r_pend;
    // Per-item working registers
    t_cmd              r_cmd;
    logic [SIZE_W-1:0] r_size;
    logic [WORD_W-1:0] r_word;
    logic [PTR_W-1:0]  r_base;
    logic [LANE_W-1:0] r_idx;
    logic [LANE_W-1:0] r_pend_lane;
    logic [WORD_W-1:0] r_acc;
    t_status           r_status;
    // Output register
    logic [WORD_W-1:0] r_read_word;
    logic [FILL_W-1:0] r_fill_level;
    t_status           r_out_status;

    logic [CHK_W-1:0]  w_in_bytes;
    t_status           w_in_status;
    logic [LANE_W-1:0] w_last_lane;
    logic [LANE_W-1:0] w_sel;
    logic [PTR_W-1:0]  w_addr;
    logic [BYTE_W-1:0] w_wdata;
    logic [BYTE_W-1:0] w_rdata;
    logic [LANE_W:0]   w_nbytes;

    // Range check of the offered item against the current fill
    always_comb begin
        w_in_bytes  = CHK_W'(1) << i_size_code;
        w_in_status = ST_OK;
        case (i_command)
            CMD_WRITE: begin
                if (CHK_W'(r_count) + w_in_bytes > CHK_W'(DEPTH)) begin
                    w_in_status = ST_OVERFLOW;
                end
            end
            CMD_READ: begin
                if (CHK_W'(r_count) < w_in_bytes) begin
                    w_in_status = ST_UNDERFLOW;
                end
            end
            CMD_PEEK: begin
                if (CHK_W'(i_peek_offset) + w_in_bytes > CHK_W'(r_count)) begin
                    w_in_status = ST_PEEK_RANGE;
                end
            end
            default: w_in_status = ST_OK;
        endcase
    end

    assign w_last_lane   = f_last_lane(r_size);
    assign w_nbytes      = (LANE_W + 1)'(1) << r_size;
    assign o_stat.cmd_in = i_command;
    assign o_stat.err_in = (w_in_status != ST_OK);
    assign o_stat.last   = (r_idx == w_last_lane);

    // Byte address and write lane: big-endian sends the top byte first
    assign w_addr  = r_base + PTR_W'(r_idx);
    assign w_sel   = r_big_endian ? (w_last_lane - r_idx) : r_idx;
    assign w_wdata = r_word[w_sel * BYTE_W +: BYTE_W];

    epbf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr_byte),
        .i_waddr (w_addr),
        .i_wdata (w_wdata),
        .i_raddr (w_addr),
        .o_rdata (w_rdata)
    );

    // Ring pointers, byte order register, read pending flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '0;
            r_count      <= '0;
            r_big_endian <= 1'b0;
            r_pend       <= 1'b0;
        end else begin
            r_pend <= i_ctl.rd_issue;
            if (i_cfg_valid) begin
                r_big_endian <= i_cfg_big_endian_order;
            end
            if (i_ctl.accept && i_command == CMD_CLEAR) begin
                r_head  <= '0;
                r_count <= '0;
            end else if (i_ctl.commit) begin
                if (r_cmd == CMD_WRITE) begin
                    r_count <= r_count + CNT_W'(w_nbytes);
                end else if (r_cmd == CMD_READ) begin
                    r_head  <= r_head + PTR_W'(w_nbytes);
                    r_count <= r_count - CNT_W'(w_nbytes);
                end
            end
        end
    end

    // Item capture, byte index and word assembly
    always_ff @(posedge i_clk) begin
        r_pend_lane <= r_idx;
        if (i_ctl.accept) begin
            r_cmd    <= i_command;
            r_size   <= i_size_code;
            r_word   <= i_write_word;
            r_status <= w_in_status;
            r_idx    <= '0;
            r_acc    <= '0;
            case (i_command)
                CMD_WRITE: r_base <= r_head + r_count[PTR_W-1:0];
                CMD_PEEK:  r_base <= r_head + PTR_W'(i_peek_offset);
                default:   r_base <= r_head;
            endcase
        end else begin
            if (i_ctl.wr_byte || i_ctl.rd_issue) begin
                r_idx <= r_idx + LANE_W'(1);
            end
            // Read data arrives in the cycle after its address
            if (r_pend) begin
                if (r_big_endian) begin
                    r_acc <= {r_acc[WORD_W-BYTE_W-1:0], w_rdata};
                end else begin
                    r_acc[r_pend_lane * BYTE_W +: BYTE_W] <= w_rdata;
                end
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (i_ctl.load_out) begin
            r_fill_level <= FILL_W'(r_count);
            r_out_status <= r_status;
            if (r_status == ST_OK && (r_cmd == CMD_READ || r_cmd == CMD_PEEK)) begin
                r_read_word <= r_acc;
            end else begin
                r_read_word <= '0;
            end
        end
    end

    assign o_read_word  = r_read_word;
    assign o_fill_level = r_fill_level;
    assign o_status     = r_out_status;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("fill count above store depth");
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.accept && i_command == CMD_CLEAR) |=> (r_count == '0 && r_head == '0))
        else $error("clear did not empty the queue");
    a_no_write_during_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !i_ctl.wr_byte)
        else $error("store write while read data pending");
`endif

endmodule

// ----- rtl/endian_packing_byte_fifo_top.sv -----
// Endian packing byte FIFO: a 1024-byte ring queue that pushes and pops words of
// 1, 2, 4 or 8 bytes in little- or big-endian byte order (set by the configuration
// write), peeks at a byte offset from the head, and clears. Every command transfer
// yields exactly one response transfer with the assembled word, the fill after the
// operation and a status; on any error the queue is unchanged. One command is in
// work at a time, moved one byte per cycle through the single byte-wide store:
// a clear or a rejected command goes from idle to done, a write steps through its
// bytes to done; a read or peek adds a drain state for the registered store read.
// A finished response waits in an output register while the next command is taken.
// The store needs no clearing after reset. Neither input takes a transfer while
// reset is held; outside reset the configuration channel is always ready.
// Depends on epbf_pkg, epbf_if, epbf_ctrl, epbf_dp and epbf_ram.
module endian_packing_byte_fifo_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    epbf_cmd_if.sink       i_cmd,
    epbf_rsp_if.source     o_rsp,
    epbf_cfg_if.sink       i_cfg
);
    import epbf_pkg::*;

    t_dp_ctl  w_ctl;
    t_dp_stat w_stat;
    t_status  w_status;
    logic     w_in_ready;
    logic     w_out_valid;

    assign i_cmd.ready = w_in_ready;
    assign i_cfg.ready = i_rst_n;
    assign o_rsp.valid = w_out_valid;
    assign o_rsp.status = w_status;

    // Sequencer
    epbf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .o_in_ready  (w_in_ready),
        .i_stat      (w_stat),
        .o_ctl       (w_ctl),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_rsp.ready)
    );

    // Pointers, store and word packing
    epbf_dp u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_ctl                  (w_ctl),
        .o_stat                 (w_stat),
        .i_command              (t_cmd'(i_cmd.command)),
        .i_size_code            (i_cmd.size_code),
        .i_write_word           (i_cmd.write_word),
        .i_peek_offset          (i_cmd.peek_offset),
        .i_cfg_valid            (i_cfg.valid),
        .i_cfg_big_endian_order (i_cfg.big_endian_order),
        .o_read_word            (o_rsp.read_word),
        .o_fill_level           (o_rsp.fill_level),
        .o_status               (w_status)
    );

endmodule

// ----- test/epbf_scoreboard.sv -----
`timescale 1ns / 1ps
// Scoreboard for the endian packing byte FIFO: keeps a mirror of the byte ring,
// predicts one response per command transfer and checks response transfers in order.
// Depends on epbf_pkg and the channel interfaces in epbf_if.
module epbf_scoreboard (
    input  logic i_clk,
    input  logic i_rst_n,
    epbf_cmd_if  i_cmd_mon,
    epbf_rsp_if  i_rsp_mon,
    epbf_cfg_if  i_cfg_mon,
    output int   o_fail_count,
    output int   o_pending
);
    import epbf_pkg::*;

    localparam int REPORT_MAX = 10;

    typedef struct {
        logic [WORD_W-1:0] word;
        logic [FILL_W-1:0] fill;
        t_status           status;
    } t_fifo_reply;

    // Mirror of the queue and of the byte order register
    logic [BYTE_W-1:0] ring_bytes [DEPTH];
    logic [PTR_W-1:0]  ring_head;
    logic [CNT_W-1:0]  ring_held;
    logic              order_big;
    t_fifo_reply       awaited_replies [$];

    initial begin
        foreach (ring_bytes[i]) ring_bytes[i] = '0;
    end

    // Rebuild a word from consecutive ring bytes in the current byte order
    function automatic logic [WORD_W-1:0] gather_word(input int start, input int nbytes);
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] byte_val;
        word = '0;
        for (int i = 0; i < nbytes; i++) begin
            byte_val = WORD_W'(ring_bytes[(start + i) % DEPTH]);
            if (order_big)
                word = (word << 8) | byte_val;
            else
                word = word | (byte_val << (8 * i));
        end
        return word;
    endfunction

    // Apply one command to the mirror and return the response it must produce
    function automatic t_fifo_reply mirror_fifo_op(input t_cmd cmd,
                                                   input logic [SIZE_W-1:0] size,
                                                   input logic [WORD_W-1:0] wdata,
                                                   input logic [OFF_W-1:0] off);
        t_fifo_reply reply;
        int          nbytes;
        int          held;
        int          shift;
        nbytes       = 1 << size;
        held         = int'(ring_held);
        reply.word   = '0;
        reply.status = ST_OK;
        case (cmd)
            CMD_WRITE: begin
                if (held + nbytes > DEPTH) begin
                    reply.status = ST_OVERFLOW;
                end else begin
                    for (int i = 0; i < nbytes; i++) begin
                        shift = order_big ? 8 * (nbytes - 1 - i) : 8 * i;
                        ring_bytes[(int'(ring_head) + held + i) % DEPTH] =
                            BYTE_W'(wdata >> shift);
                    end
                    ring_held = CNT_W'(held + nbytes);
                end
            end
            CMD_READ: begin
                if (held < nbytes) begin
                    reply.status = ST_UNDERFLOW;
                end else begin
                    reply.word = gather_word(int'(ring_head), nbytes);
                    ring_head  = PTR_W'((int'(ring_head) + nbytes) % DEPTH);
                    ring_held  = CNT_W'(held - nbytes);
                end
            end
            CMD_PEEK: begin
                if (int'(off) + nbytes > held)
                    reply.status = ST_PEEK_RANGE;
                else
                    reply.word = gather_word(int'(ring_head) + int'(off), nbytes);
            end
            default: begin
                ring_head = '0;
                ring_held = '0;
            end
        endcase
        reply.fill = FILL_W'(ring_held);
        return reply;
    endfunction

    function automatic void flag_reply(input string what, input t_fifo_reply want);
        if (o_fail_count < REPORT_MAX)
            $display("%0t ns: %s: expected word %h fill %0d status %s, %s %h %s %0d %s %0d",
                     $time, what, want.word, want.fill, want.status.name(),
                     "got word", i_rsp_mon.read_word, "fill", i_rsp_mon.fill_level,
                     "status", i_rsp_mon.status);
        o_fail_count++;
    endfunction

    // Transfers are sampled at the rising edge: config, then command, then response
    always @(posedge i_clk) begin
        t_fifo_reply want;
        if (!i_rst_n) begin
            ring_head    = '0;
            ring_held    = '0;
            order_big    = 1'b0;
            o_fail_count = 0;
            awaited_replies.delete();
        end else begin
            if (i_cfg_mon.valid && i_cfg_mon.ready)
                order_big = i_cfg_mon.big_endian_order;
            if (i_cmd_mon.valid && i_cmd_mon.ready)
                awaited_replies = {awaited_replies,
                                   mirror_fifo_op(t_cmd'(i_cmd_mon.command),
                                                  i_cmd_mon.size_code,
                                                  i_cmd_mon.write_word,
                                                  i_cmd_mon.peek_offset)};
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                if (awaited_replies.size() == 0) begin
                    want = '{word: '0, fill: '0, status: ST_OK};
                    flag_reply("response with no command outstanding", want);
                end else begin
                    want = awaited_replies[0];
                    awaited_replies.delete(0);
                    if (i_rsp_mon.read_word !== want.word ||
                        i_rsp_mon.fill_level !== want.fill ||
                        i_rsp_mon.status !== want.status)
                        flag_reply("response mismatch", want);
                end
            end
        end
        o_pending = awaited_replies.size();
    end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// Top of the endian packing byte FIFO testbench: clock, reset, command and byte order
// stimulus, response back-pressure and the verdict.
// Depends on epbf_pkg, epbf_if, endian_packing_byte_fifo_top and epbf_scoreboard.
module testbench;
    import epbf_pkg::*;

    typedef enum int {
        MIX_BALANCED,
        MIX_FILL,
        MIX_DRAIN
    } t_op_mix;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_PCT      = 14;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 20;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    int src_idle_pct = IDLE_PCT;
    int snk_idle_pct = IDLE_PCT;
    int hold_asked   = 0;
    int hold_taken   = 0;
    int hold_left    = 0;
    int cycle_count  = 0;
    int fail_count;
    int pending;

    epbf_cmd_if cmd_bus ();
    epbf_rsp_if rsp_bus ();
    epbf_cfg_if cfg_bus ();

    endian_packing_byte_fifo_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_bus),
        .o_rsp   (rsp_bus),
        .i_cfg   (cfg_bus)
    );

    epbf_scoreboard scb (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_mon    (cmd_bus),
        .i_rsp_mon    (rsp_bus),
        .i_cfg_mon    (cfg_bus),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Response back-pressure: random stalls, plus one long hold-off when asked
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_bus.ready = 1'b0;
        end else if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
        end else if (hold_taken != hold_asked) begin
            hold_taken    = hold_asked;
            hold_left     = HOLD_CYCLES - 1;
            rsp_bus.ready = 1'b0;
        end else begin
            rsp_bus.ready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // Run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("endian_packing_byte_fifo_top test failed");
        $finish;
    end

    // Offer one command, with random idle cycles ahead of it, until it transfers
    task automatic send_op(input t_cmd cmd, input logic [1:0] size,
                           input logic [63:0] wdata, input logic [9:0] off);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            cmd_bus.valid = 1'b0;
            @(negedge i_clk);
        end
        cmd_bus.valid       = 1'b1;
        cmd_bus.command     = cmd;
        cmd_bus.size_code   = size;
        cmd_bus.write_word  = wdata;
        cmd_bus.peek_offset = off;
        @(posedge i_clk);
        while (!cmd_bus.ready) @(posedge i_clk);
    endtask

    // Stop offering and wait until every response has come back
    task automatic wait_drained();
        @(negedge i_clk);
        cmd_bus.valid = 1'b0;
        wait (pending == 0);
    endtask

    task automatic write_order(input logic big);
        @(negedge i_clk);
        cfg_bus.valid            = 1'b1;
        cfg_bus.big_endian_order = big;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    // Random command; fill and drain mixes favor 8-byte words to move the fill fast
    task automatic send_random_op(input t_op_mix mix);
        int         pick;
        int         wr_cut;
        int         rd_cut;
        int         pk_cut;
        t_cmd       cmd;
        logic [1:0] size;
        logic [9:0] off;
        case (mix)
            MIX_FILL: begin
                wr_cut = 85; rd_cut = 90; pk_cut = 100;
            end
            MIX_DRAIN: begin
                wr_cut = 10; rd_cut = 80; pk_cut = 100;
            end
            default: begin
                wr_cut = 40; rd_cut = 70; pk_cut = 97;
            end
        endcase
        pick = $urandom_range(99);
        if (pick < wr_cut)
            cmd = CMD_WRITE;
        else if (pick < rd_cut)
            cmd = CMD_READ;
        else if (pick < pk_cut)
            cmd = CMD_PEEK;
        else
            cmd = CMD_CLEAR;
        if (mix != MIX_BALANCED && $urandom_range(9) < 6)
            size = 2'd3;
        else
            size = 2'($urandom_range(3));
        case ($urandom_range(9))
            0, 1, 2, 3, 4: off = 10'($urandom_range(15));
            5, 6, 7:       off = 10'($urandom_range(255));
            default:       off = 10'($urandom_range(1023));
        endcase
        send_op(cmd, size, {$urandom, $urandom}, off);
    endtask

    // One random phase under a fixed byte order, written while the block is idle
    task automatic run_phase(input t_op_mix mix, input int count, input logic big);
        wait_drained();
        write_order(big);
        repeat (count) send_random_op(mix);
    endtask

    initial begin
        cmd_bus.valid            = 1'b0;
        cmd_bus.command          = CMD_WRITE;
        cmd_bus.size_code        = 2'd0;
        cmd_bus.write_word       = '0;
        cmd_bus.peek_offset      = '0;
        cfg_bus.valid            = 1'b0;
        cfg_bus.big_endian_order = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Little-endian: empty-queue errors, every size, peek bounds, drain to empty
        write_order(1'b0);
        send_op(CMD_READ,  2'd0, 64'h0, 10'd0);
        send_op(CMD_PEEK,  2'd3, 64'h0, 10'd0);
        send_op(CMD_WRITE, 2'd0, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0);
        send_op(CMD_WRITE, 2'd1, 64'h0000_0000_0000_A55A, 10'd0);
        send_op(CMD_WRITE, 2'd2, 64'hDEAD_BEEF_1122_3344, 10'd0);
        send_op(CMD_WRITE, 2'd3, 64'h0123_4567_89AB_CDEF, 10'd0);
        send_op(CMD_PEEK,  2'd3, 64'h0, 10'd7);
        send_op(CMD_PEEK,  2'd3, 64'h0, 10'd8);
        send_op(CMD_PEEK,  2'd0, 64'h0, 10'd1023);
        send_op(CMD_PEEK,  2'd2, 64'h0, 10'd3);
        send_op(CMD_READ,  2'd0, 64'h0, 10'd0);
        send_op(CMD_READ,  2'd1, 64'h0, 10'd0);
        send_op(CMD_READ,  2'd2, 64'h0, 10'd0);
        send_op(CMD_READ,  2'd3, 64'h0, 10'd0);
        send_op(CMD_READ,  2'd3, 64'h0, 10'd0);

        // Big-endian: packing order, peeks, clear and a read after clear
        wait_drained();
        write_order(1'b1);
        send_op(CMD_WRITE, 2'd3, 64'hFEDC_BA98_7654_3210, 10'd0);
        send_op(CMD_PEEK,  2'd0, 64'h0, 10'd0);
        send_op(CMD_PEEK,  2'd1, 64'h0, 10'd6);
        send_op(CMD_READ,  2'd2, 64'h0, 10'd0);
        send_op(CMD_WRITE, 2'd0, 64'h0, 10'd0);
        send_op(CMD_CLEAR, 2'd0, 64'h0, 10'd0);
        send_op(CMD_READ,  2'd0, 64'h0, 10'd0);
        send_op(CMD_WRITE, 2'd3, 64'hFFFF_FFFF_FFFF_FFFF, 10'd0);
        send_op(CMD_READ,  2'd3, 64'h0, 10'd0);

        run_phase(MIX_BALANCED, 60, 1'b0);

        // Receiver holds off while the queue is filled toward overflow
        wait_drained();
        write_order(1'b1);
        hold_asked++;
        repeat (240) send_random_op(MIX_FILL);

        // Long stretch with no idling on either side while draining
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_phase(MIX_DRAIN, 200, 1'b1);
        src_idle_pct = IDLE_PCT;
        snk_idle_pct = IDLE_PCT;

        run_phase(MIX_BALANCED, 100, 1'b0);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("endian_packing_byte_fifo_top test passed");
        else
            $display("endian_packing_byte_fifo_top test failed");
        $finish;
    end

endmodule
